### hw/rtl/eqxo_pkg.sv
// Shared constants, types and control structs for the EQ/crossover audio path.
// Used by every module of the block except eqxo_ram; no dependencies of its own.
`timescale 1ns / 1ps
package eqxo_pkg;

  localparam int NUM_EQ_BANDS = 10;
  localparam int SECTIONS     = NUM_EQ_BANDS + 2;
  localparam int COEF_COUNT   = SECTIONS * 5;
  localparam int DELAY_COUNT  = SECTIONS * 2;
  localparam int LPF_SECTION  = NUM_EQ_BANDS;
  localparam int HPF_SECTION  = NUM_EQ_BANDS + 1;
  localparam int SEC_W        = $clog2(SECTIONS);
  localparam int COEF_AW      = $clog2(COEF_COUNT);
  localparam int DLY_AW       = $clog2(DELAY_COUNT);

  localparam logic [15:0] MIX_GAIN_RESET = 16'd11469;

  // Request opcodes.
  localparam logic [1:0] OP_FRAME   = 2'd0;
  localparam logic [1:0] OP_COEF_WR = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_EQ_ENABLE = 2'd0;
  localparam logic [1:0] CFG_MIX_GAIN  = 2'd1;

  // Biquad tap positions inside a section.
  localparam int TAP_B0 = 0;
  localparam int TAP_B1 = 1;
  localparam int TAP_B2 = 2;
  localparam int TAP_A1 = 3;
  localparam int TAP_A2 = 4;

  // Controller phases; C0..C8 are the nine steps of one biquad section.
  typedef enum logic [3:0] {
    PH_IDLE, PH_MIX, PH_C0, PH_C1, PH_C2, PH_C3, PH_C4, PH_C5, PH_C6, PH_C7, PH_C8, PH_OUT
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [SEC_W-1:0] sec;
    logic             take;
    logic             load_out;
  } eqxo_cmd_t;

endpackage

### hw/rtl/eqxo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module eqxo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/eqxo_ctrl.sv
// Controller state machine: sequences frames through the mix step, the biquad
// sections and the output register. Depends on eqxo_pkg.
`timescale 1ns / 1ps
module eqxo_ctrl import eqxo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] opcode,
  input  logic       eq_enable,
  input  logic       out_tready,
  output logic       out_tvalid,
  output eqxo_cmd_t  cmd
);

  phase_t           state_r, state_nxt;
  logic [SEC_W-1:0] sec_r, sec_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State, section counter and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_IDLE;
      sec_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and command outputs.
  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    in_tready     = 1'b0;
    cmd.take      = 1'b0;
    cmd.load_out  = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      PH_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (opcode == OP_FRAME) begin
            state_nxt = eq_enable ? PH_MIX : PH_OUT;
          end
        end
      end
      PH_MIX: begin
        sec_nxt   = '0;
        state_nxt = PH_C0;
      end
      PH_C0: state_nxt = PH_C1;
      PH_C1: state_nxt = PH_C2;
      PH_C2: state_nxt = PH_C3;
      PH_C3: state_nxt = PH_C4;
      PH_C4: state_nxt = PH_C5;
      PH_C5: state_nxt = PH_C6;
      PH_C6: state_nxt = PH_C7;
      PH_C7: state_nxt = PH_C8;
      PH_C8: begin
        if (sec_r == SEC_W'(SECTIONS - 1)) begin
          state_nxt = PH_OUT;
        end else begin
          sec_nxt   = sec_r + 1'b1;
          state_nxt = PH_C0;
        end
      end
      PH_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = PH_IDLE;
        end
      end
      default: state_nxt = PH_IDLE;
    endcase
    cmd.phase = state_r;
    cmd.sec   = sec_r;
  end

  assign out_tvalid = out_valid_r;

endmodule

### hw/rtl/eqxo_dp.sv
// Datapath: coefficient and delay memories, the shared 32x32 multiplier with
// its accumulator, the mono mix and the PCM output stage. Depends on eqxo_pkg, eqxo_ram.
`timescale 1ns / 1ps
module eqxo_dp import eqxo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  eqxo_cmd_t          cmd,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] left_in,
  input  logic signed [15:0] right_smp,
  input  logic [5:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic               block_end,
  input  logic               eq_enable,
  input  logic [15:0]        mix_gain,
  output logic signed [15:0] mid_out,
  output logic signed [15:0] sub_out,
  output logic               block_end_out
);

  // Round half up by 2^26 and saturate to 32 bits.
  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = (v + 64'sd33554432) >>> 26;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Scale by 32767, truncate toward zero, clamp to int16.
  function automatic logic signed [15:0] to_pcm(input logic signed [31:0] y);
    logic signed [47:0] p;
    logic signed [47:0] q;
    p = (48'(y) <<< 15) - 48'(y);
    q = (p < 0) ? ((p + 48'sd134217727) >>> 27) : (p >>> 27);
    if (q > 48'sd32767) return 16'sh7fff;
    if (q < -48'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  logic signed [15:0] left_r, right_r;
  logic               bend_r, bypass_r;
  logic signed [31:0] x_r, w0_r, w1_r, d_r, coef_r, sub_r, mid_r;
  logic signed [61:0] prod_r;
  logic signed [63:0] acc_r;
  logic [DELAY_COUNT-1:0] dly_vld_r;
  logic signed [15:0] mid_out_r, sub_out_r;
  logic               bend_out_r;
  logic [DLY_AW-1:0]  dly_raddr_q;

  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic               coef_we;
  logic signed [31:0] coef_q;
  logic [DLY_AW-1:0]  dly_waddr, dly_raddr, dly_base;
  logic               dly_we;
  logic signed [31:0] dly_wdata, dly_q, dly_rd;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_full;
  logic signed [31:0] y_val;
  logic signed [33:0] mix_prod;
  logic [2:0]         tap;

  // Memory addressing for the current section and step.
  always_comb begin
    case (cmd.phase)
      PH_C0:   tap = 3'(TAP_A1);
      PH_C1:   tap = 3'(TAP_A2);
      PH_C2:   tap = 3'(TAP_B0);
      PH_C4:   tap = 3'(TAP_B1);
      default: tap = 3'(TAP_B2);
    endcase
    coef_raddr = COEF_AW'(32'(cmd.sec) * 5 + 32'(tap));
    coef_waddr = COEF_AW'(coef_index);
    coef_we    = cmd.take && (opcode == OP_COEF_WR) && (32'(coef_index) < COEF_COUNT);
    dly_base   = DLY_AW'(32'(cmd.sec) * 2);
    dly_raddr  = (cmd.phase == PH_C1) ? dly_base + 1'b1 : dly_base;
    dly_we     = (cmd.phase == PH_C5) || (cmd.phase == PH_C6);
    dly_waddr  = (cmd.phase == PH_C5) ? dly_base + 1'b1 : dly_base;
    dly_wdata  = (cmd.phase == PH_C5) ? w0_r : d_r;
    dly_rd     = dly_vld_r[dly_raddr_q] ? dly_q : 32'sd0;
  end

  eqxo_ram #(.WIDTH(32), .DEPTH(COEF_COUNT)) u_coef_ram (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(coef_value),
    .raddr(coef_raddr), .rdata(coef_q)
  );

  eqxo_ram #(.WIDTH(32), .DEPTH(DELAY_COUNT)) u_dly_ram (
    .clk(clk), .we(dly_we), .waddr(dly_waddr), .wdata(dly_wdata),
    .raddr(dly_raddr), .rdata(dly_q)
  );

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.phase)
      PH_C3, PH_C7: mul_b = w1_r;
      PH_C5:        mul_b = d_r;
      default:      mul_b = w0_r;
    endcase
    mul_full = coef_r * mul_b;
    y_val    = rnd_sat(acc_r + 64'(prod_r));
    mix_prod = (34'(left_r) + 34'(right_r)) * $signed({18'd0, mix_gain});
  end

  // Delay valid bits: cleared by reset and the clear request, set on write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else if (cmd.take && (opcode == OP_CLEAR)) begin
      dly_vld_r <= '0;
    end else if (dly_we) begin
      dly_vld_r[dly_waddr] <= 1'b1;
    end
  end

  // Section arithmetic and frame registers.
  always_ff @(posedge clk) begin
    dly_raddr_q <= dly_raddr;
    prod_r      <= mul_full[63:2];
    if (cmd.take && (opcode == OP_FRAME)) begin
      left_r   <= left_in;
      right_r  <= right_smp;
      bend_r   <= block_end;
      bypass_r <= !eq_enable;
    end
    case (cmd.phase)
      PH_MIX: x_r <= 32'((mix_prod + 34'sd4) >>> 3);
      PH_C1: begin
        w0_r   <= dly_rd;
        coef_r <= coef_q;
        acc_r  <= 64'(x_r) <<< 26;
      end
      PH_C2: begin
        w1_r   <= dly_rd;
        coef_r <= coef_q;
      end
      PH_C3: begin
        coef_r <= coef_q;
        acc_r  <= acc_r - 64'(prod_r);
      end
      PH_C4: d_r <= rnd_sat(acc_r - 64'(prod_r));
      PH_C5: coef_r <= coef_q;
      PH_C6: begin
        coef_r <= coef_q;
        acc_r  <= 64'(prod_r);
      end
      PH_C7: acc_r <= acc_r + 64'(prod_r);
      PH_C8: begin
        if (32'(cmd.sec) == LPF_SECTION) begin
          sub_r <= y_val;
        end else if (32'(cmd.sec) == HPF_SECTION) begin
          mid_r <= y_val;
        end else begin
          x_r <= y_val;
        end
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      mid_out_r  <= bypass_r ? left_r : to_pcm(mid_r);
      sub_out_r  <= bypass_r ? right_r : to_pcm(sub_r);
      bend_out_r <= bend_r;
    end
  end

  assign mid_out       = mid_out_r;
  assign sub_out       = sub_out_r;
  assign block_end_out = bend_out_r;

endmodule

### hw/rtl/eq_crossover_audio_path_core.sv
// Mono-summing parametric EQ with two-way crossover, controller plus shared-MAC datapath.
// Depends on eqxo_pkg, eqxo_ctrl, eqxo_dp and eqxo_ram.
`timescale 1ns / 1ps
// A filtered audio frame passes from acceptance through the mix step and every biquad
// section to the output register: one 32x32 multiplier and single-port reads of the
// coefficient and delay memories give nine steps per biquad section. A bypassed frame
// goes from acceptance straight to the output state; coefficient writes and state clears
// finish on acceptance. The block takes one request at a time, and a finished result waits
// in the output register while the next request is accepted; a frame that finishes while
// that result still waits holds until it is taken. Coefficients must be written before a
// filtered frame uses them.
module eq_crossover_audio_path_core import eqxo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] left_in, [31:16] right_in, [37:32] coef_index, [69:38] coef_value, [71:70] zero
  input  logic [71:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] mid_out, [31:16] sub_out
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        eq_enable_r;
  logic [15:0] mix_gain_r;
  eqxo_cmd_t   cmd;
  logic signed [15:0] mid_s, sub_s;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_enable_r <= 1'b0;
      mix_gain_r  <= MIX_GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EQ_ENABLE: eq_enable_r <= cfg_data[0];
        CFG_MIX_GAIN:  mix_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  eqxo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .opcode(in_tuser), .eq_enable(eq_enable_r), .out_tready(out_tready),
    .out_tvalid(out_tvalid), .cmd(cmd)
  );

  eqxo_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .opcode(in_tuser),
    .left_in(in_tdata[15:0]), .right_smp(in_tdata[31:16]),
    .coef_index(in_tdata[37:32]), .coef_value(in_tdata[69:38]),
    .block_end(in_tlast), .eq_enable(eq_enable_r), .mix_gain(mix_gain_r),
    .mid_out(mid_s), .sub_out(sub_s), .block_end_out(out_tlast)
  );

  assign out_tdata = {sub_s, mid_s};

  // A waiting result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped before it was taken");

  // Coefficient writes and clears never raise a new result.
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_COEF_WR || in_tuser == OP_CLEAR) && !out_tvalid
    |=> !out_tvalid)
    else $error("result raised by a non-frame request");

endmodule

### tb/eq_crossover_audio_path_checker.sv
// Checker for the EQ/crossover audio path: watches the request, result and register channels,
// predicts each result with its own filter arithmetic, and compares. Depends on eqxo_pkg.
`timescale 1ns / 1ps
module eq_crossover_audio_path_checker import eqxo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] mid;
    logic [15:0] sub;
    logic        blk_end;
  } pcm_pair_t;

  logic signed [31:0] coefs [COEF_COUNT];
  logic signed [31:0] delays [DELAY_COUNT];
  logic               eq_on;
  logic [15:0]        gain;
  pcm_pair_t          expected_pcm [$];

  assign pending = expected_pcm.size();

  // Rounds half up after an arithmetic (floor) shift, then saturates to 32 bits.
  function automatic logic signed [31:0] round_sat(longint v, int s);
    longint r;
    r = (v + (longint'(1) << (s - 1))) >>> s;
    if (r > 64'sd2147483647) return 32'h7fffffff;
    if (r < -64'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  function automatic longint mac_term(logic signed [31:0] c, logic signed [31:0] s);
    return (longint'(c) * longint'(s)) >>> 2;
  endfunction

  // One direct form II section; updates that section's delay pair.
  function automatic logic signed [31:0] run_section(int sec, logic signed [31:0] x);
    logic signed [31:0] w0, w1, d, y;
    longint acc;
    w0 = delays[sec*2];
    w1 = delays[sec*2+1];
    acc = longint'(x) * 64'sd67108864 - mac_term(coefs[sec*5+TAP_A1], w0)
          - mac_term(coefs[sec*5+TAP_A2], w1);
    d = round_sat(acc, 26);
    acc = mac_term(coefs[sec*5+TAP_B0], d) + mac_term(coefs[sec*5+TAP_B1], w0)
          + mac_term(coefs[sec*5+TAP_B2], w1);
    y = round_sat(acc, 26);
    delays[sec*2+1] = w0;
    delays[sec*2] = d;
    return y;
  endfunction

  // Scales Q4.27 to PCM, truncating toward zero, and clamps to int16.
  function automatic logic [15:0] to_sample(logic signed [31:0] y);
    longint p, q;
    p = longint'(y) * 64'sd32767;
    q = (p >= 0) ? (p >>> 27) : -((-p) >>> 27);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic pcm_pair_t filter_frame(logic signed [15:0] l, logic signed [15:0] r,
                                             logic bend);
    pcm_pair_t res;
    logic signed [31:0] x, lo, hi;
    longint m;
    m = (longint'(l) + longint'(r)) * longint'({1'b0, gain});
    x = 32'((m + 4) >>> 3);
    for (int b = 0; b < NUM_EQ_BANDS; b++) x = run_section(b, x);
    lo = run_section(LPF_SECTION, x);
    hi = run_section(HPF_SECTION, x);
    res.mid = to_sample(hi);
    res.sub = to_sample(lo);
    res.blk_end = bend;
    return res;
  endfunction

  always @(posedge clk) begin
    pcm_pair_t got, want;
    logic [5:0] idx;
    if (!rst_n) begin
      eq_on <= 1'b0;
      gain <= MIX_GAIN_RESET;
      for (int i = 0; i < DELAY_COUNT; i++) delays[i] = '0;
      expected_pcm.delete();
      fail_count <= 0;
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_EQ_ENABLE) eq_on <= cfg_data[0];
        else if (cfg_index == CFG_MIX_GAIN) gain <= cfg_data;
      end
      // Accepted requests.
      if (in_tvalid && in_tready) begin
        idx = in_tdata[37:32];
        case (in_tuser)
          OP_COEF_WR: if (idx < COEF_COUNT) coefs[idx] = in_tdata[69:38];
          OP_CLEAR: for (int i = 0; i < DELAY_COUNT; i++) delays[i] = '0;
          OP_FRAME: begin
            if (eq_on) want = filter_frame(in_tdata[15:0], in_tdata[31:16], in_tlast);
            else want = '{mid: in_tdata[15:0], sub: in_tdata[31:16], blk_end: in_tlast};
            expected_pcm.push_back(want);
          end
          default: ;
        endcase
      end
      // Accepted results.
      if (out_tvalid && out_tready) begin
        got = '{mid: out_tdata[15:0], sub: out_tdata[31:16], blk_end: out_tlast};
        if (expected_pcm.size() == 0) begin
          if (fail_count < 10) $display("unexpected result mid=%h sub=%h", got.mid, got.sub);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pcm.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: mid %h/%h sub %h/%h last %b/%b (expected/actual)",
                       want.mid, got.mid, want.sub, got.sub, want.blk_end, got.blk_end);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### tb/eq_crossover_audio_path_core_tb.sv
// Stimulus and verdict for the EQ/crossover audio path: directed corner requests, then
// random phases under several register settings. Depends on eqxo_pkg, the core and the checker.
`timescale 1ns / 1ps
module eq_crossover_audio_path_core_tb import eqxo_pkg::*;;

  // Codes the block must ignore.
  localparam logic [1:0] OP_RESERVED  = 2'd3;
  localparam logic [1:0] CFG_RESERVED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_FRAME;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_EQ_ENABLE;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  logic        stalls_on = 1'b1;
  int          stall_left = 0;

  eq_crossover_audio_path_core u_top (.*);

  eq_crossover_audio_path_checker u_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  // Result-side backpressure in random bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Issues one request and holds it until accepted, with an optional idle burst first.
  task automatic send_req(logic [1:0] op, logic [15:0] l, logic [15:0] r, logic [5:0] idx,
                          logic [31:0] cv, logic last);
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, cv, idx, r, l};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops the sender until every expected result has come and the core has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] mild_coef(int tap);
    int spread;
    spread = (tap == TAP_B0) ? (1 << 24) : ((tap == TAP_A1) ? (1 << 26) : (1 << 25));
    return ((tap == TAP_B0) ? (1 << 28) : 0) + $urandom_range(0, 2 * spread) - spread;
  endfunction

  // Loads every section; hot sets use full-range coefficients to drive saturation.
  task automatic load_coefs(logic hot);
    for (int i = 0; i < COEF_COUNT; i++)
      send_req(OP_COEF_WR, 16'($urandom), 16'($urandom), 6'(i),
               hot ? 32'($urandom) : mild_coef(i % 5), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_req();
    int pick;
    logic [5:0] idx;
    pick = $urandom_range(0, 99);
    idx = 6'($urandom_range(0, 63));
    if (pick < 80)
      send_req(OP_FRAME, 16'($urandom), 16'($urandom), idx, 32'($urandom),
               1'($urandom_range(0, 1)));
    else if (pick < 90)
      send_req(OP_COEF_WR, 16'($urandom), 16'($urandom), idx,
               ($urandom_range(0, 3) == 0) ? 32'($urandom) : mild_coef(int'(idx) % 5),
               1'($urandom_range(0, 1)));
    else if (pick < 95)
      send_req(OP_CLEAR, 16'($urandom), 16'($urandom), idx, 32'($urandom),
               1'($urandom_range(0, 1)));
    else
      send_req(OP_RESERVED, 16'($urandom), 16'($urandom), idx, 32'($urandom),
               1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bypass at reset, ignored requests and the unused register index.
    write_reg(CFG_RESERVED, 16'hffff);
    send_req(OP_FRAME, 16'h8000, 16'h7fff, 6'd0, 32'd0, 1'b1);
    send_req(OP_FRAME, 16'h7fff, 16'h8000, 6'd0, 32'd0, 1'b0);
    send_req(OP_FRAME, 16'hffff, 16'h0000, 6'd0, 32'd0, 1'b1);
    send_req(OP_RESERVED, 16'h1234, 16'h5678, 6'd7, 32'hdeadbeef, 1'b1);
    send_req(OP_CLEAR, 16'h0, 16'h0, 6'd0, 32'd0, 1'b0);
    send_req(OP_COEF_WR, 16'h0, 16'h0, 6'd63, 32'h7fffffff, 1'b0);

    // Filtered frames at the gain extremes, with extreme coefficients in the first band and the low-pass section.
    load_coefs(1'b0);
    send_req(OP_COEF_WR, 16'h0, 16'h0, 6'd3, 32'h80000000, 1'b0);
    send_req(OP_COEF_WR, 16'h0, 16'h0, 6'(5 * LPF_SECTION), 32'h7fffffff, 1'b0);
    wait_idle();
    write_reg(CFG_EQ_ENABLE, 16'h0001);
    write_reg(CFG_MIX_GAIN, 16'hffff);
    send_req(OP_FRAME, 16'h7fff, 16'h7fff, 6'd0, 32'd0, 1'b0);
    send_req(OP_FRAME, 16'h8000, 16'h8000, 6'd0, 32'd0, 1'b1);
    send_req(OP_FRAME, 16'h7fff, 16'h8000, 6'd0, 32'd0, 1'b0);
    send_req(OP_CLEAR, 16'h0, 16'h0, 6'd0, 32'd0, 1'b0);
    wait_idle();
    write_reg(CFG_MIX_GAIN, 16'h0000);
    send_req(OP_FRAME, 16'h7fff, 16'h7fff, 6'd0, 32'd0, 1'b1);
    send_req(OP_FRAME, 16'h8000, 16'h1234, 6'd0, 32'd0, 1'b0);

    // Random phases under changing settings; the last one runs without idle bursts or result backpressure.
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 5) stalls_on = 1'b0;
      write_reg(CFG_EQ_ENABLE, (ph == 1) ? 16'hfffe : 16'($urandom_range(0, 1)) | 16'(ph > 3));
      write_reg(CFG_MIX_GAIN, (ph == 2) ? 16'hffff : (ph == 3) ? 16'h0 : 16'($urandom));
      if (ph == 2) load_coefs(1'b1);
      else if (ph == 3) load_coefs(1'b0);
      for (int n = 0; n < 300; n++) begin
        if (n == 150) wait_idle();
        random_req();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
